### sv/sorted_key_index_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Sorted key index table - assertion macros
// Concurrent assertion wrappers. Both compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_INDEX_TABLE_UNIT_DEFINES_SVH
`define SORTED_KEY_INDEX_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk, disabled while rst_n is low.
`define SKIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: %s", msg);
// Checked on every rising edge of clk, also during reset.
`define SKIT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: %s", msg);
`else
`define SKIT_ASSERT(lbl, prop, msg)
`define SKIT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### sv/skit_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key index table - package
// Sizes, request and status codes, and the types shared by the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package skit_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int RECORD_BITS = 16;

  localparam int KEY_W      = 34;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int RECNUM_W   = 16;
  localparam int POS_W      = 8;
  localparam int ENTCNT_W   = 9;

  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int NREC_W     = RECORD_BITS + 1;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STS_DUP       = 3'd3;
  localparam logic [STATUS_W-1:0] STS_EXHAUSTED = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_t;

  typedef enum logic {
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [RECORD_BITS-1:0] rec;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             cmp;
    logic [KEY_W-1:0] cmp_key;
    logic             upd;
    cell_op_t         op;
    entry_t           new_entry;
  } cell_ctl_t;

  // Result of resolving the compare flags of the whole chain.
  typedef struct packed {
    logic [CNT_W-1:0]       slot;
    logic                   hit;
    logic [RECORD_BITS-1:0] hit_rec;
  } resolve_t;

endpackage

`default_nettype wire

### sv/skit_chan_if.sv
// ----------------------------------------------------------------------------
// Sorted key index table - channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface skit_req_if import skit_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface skit_rsp_if import skit_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [RECNUM_W-1:0] record_number;
  logic [POS_W-1:0]    position;
  logic [ENTCNT_W-1:0] entry_count;

  modport source (output valid, output status, output record_number,
                  output position, output entry_count, input ready);
  modport sink   (input valid, input status, input record_number,
                  input position, input entry_count, output ready);
endinterface

`default_nettype wire

### sv/sorted_key_index_table_unit.sv
// ----------------------------------------------------------------------------
// Sorted key index table unit
// The request is registered into ST_WORK; the response register is loaded
// from ST_WORK once it is free, and a waiting response holds ST_WORK.
// A new request is taken only after the previous one has loaded its response,
// following the chain-wide compare and then the resolve-and-shift step.
// Reset clears the entry count and record counter; cell contents are kept.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_index_table_unit_defines.svh"

module sorted_key_index_table_unit import skit_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  skit_req_if.sink          in_req,
  skit_rsp_if.source        out_rsp
);

  // Operation flow. In ST_IDLE the unit takes a request transaction; on that
  // same edge every cell compares its entry against the request key and
  // registers a less-than and an equal flag. In ST_WORK the flags are
  // resolved into the sorted slot and the hit record, the status is decided,
  // and (for a successful insert or delete) all cells at or above the slot
  // shift by one place on the edge that loads the response register. When
  // the previous response is still waiting, ST_WORK simply holds; nothing in
  // the table changes until the response can be loaded.

  state_t                 state_r, state_nxt;
  logic [REQ_W-1:0]       req_r;
  logic [KEY_W-1:0]       key_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [NREC_W-1:0]      nrec_r, nrec_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic [RECORD_BITS-1:0] rec_r, rec_nxt;
  logic [CNT_W-1:0]       pos_r, pos_nxt;

  logic                   in_fire;
  logic                   done;
  logic                   full;
  logic                   exhausted;
  logic                   upd;
  cell_op_t               op;
  cell_ctl_t              ctl;
  resolve_t               res;

  logic [TABLE_DEPTH-1:0] lt_vec;
  logic [TABLE_DEPTH-1:0] eq_vec;
  entry_t                 entries [TABLE_DEPTH];

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign done         = (state_r == ST_WORK) && (!out_valid_r || out_rsp.ready);
  assign full         = (count_r == CNT_W'(TABLE_DEPTH));
  // The record counter has run past the last usable number.
  assign exhausted    = nrec_r[RECORD_BITS];

  // Compare uses the live request key; a new entry uses the captured one.
  assign ctl.cmp                 = in_fire;
  assign ctl.cmp_key             = in_req.key;
  assign ctl.upd                 = upd;
  assign ctl.op                  = op;
  assign ctl.new_entry.key       = key_r;
  assign ctl.new_entry.rec       = nrec_r[RECORD_BITS-1:0];

  // The cell chain. Cell 0 has no lower neighbor, so it sees a less-than
  // flag of one and takes the new entry when the slot is zero. The top cell
  // has no upper neighbor and keeps its own entry on a delete.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic   prev_lt;
    entry_t prev_entry;
    entry_t next_entry;
    logic   entry_valid;

    if (i == 0) begin : g_first
      assign prev_lt    = 1'b1;
      assign prev_entry = ctl.new_entry;
    end else begin : g_mid
      assign prev_lt    = lt_vec[i-1];
      assign prev_entry = entries[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign next_entry = entries[i];
    end else begin : g_up
      assign next_entry = entries[i+1];
    end

    assign entry_valid = (CNT_W'(i) < count_r);

    skit_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .entry_valid (entry_valid),
      .prev_lt     (prev_lt),
      .prev_entry  (prev_entry),
      .next_entry  (next_entry),
      .entry       (entries[i]),
      .lt          (lt_vec[i]),
      .eq          (eq_vec[i])
    );
  end

  skit_resolve u_resolve (
    .lt_vec  (lt_vec),
    .eq_vec  (eq_vec),
    .entries (entries),
    .res     (res)
  );

  // Next state, status decision and table update.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    nrec_nxt      = nrec_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    status_nxt    = STS_NOT_FOUND;
    rec_nxt       = '0;
    pos_nxt       = '0;
    upd           = 1'b0;
    op            = CELL_INS;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        if (done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          case (req_r)
            REQ_LOOKUP: begin
              if (res.hit) begin
                status_nxt = STS_OK;
                rec_nxt    = res.hit_rec;
                pos_nxt    = res.slot;
              end
            end
            REQ_INSERT: begin
              // Full wins over exhausted, which wins over duplicate.
              if (full) begin
                status_nxt = STS_FULL;
              end else if (exhausted) begin
                status_nxt = STS_EXHAUSTED;
              end else if (res.hit) begin
                status_nxt = STS_DUP;
              end else begin
                status_nxt = STS_OK;
                rec_nxt    = nrec_r[RECORD_BITS-1:0];
                pos_nxt    = res.slot;
                upd        = 1'b1;
                op         = CELL_INS;
                count_nxt  = count_r + CNT_W'(1);
                nrec_nxt   = nrec_r + NREC_W'(1);
              end
            end
            REQ_DELETE: begin
              if (res.hit) begin
                status_nxt = STS_OK;
                rec_nxt    = res.hit_rec;
                pos_nxt    = res.slot;
                upd        = 1'b1;
                op         = CELL_DEL;
                count_nxt  = count_r - CNT_W'(1);
              end
            end
            default: begin
              // The unused request code reads as not found.
              status_nxt = STS_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      nrec_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      nrec_r      <= nrec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request capture and response payload carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_req.req_type;
      key_r <= in_req.key;
    end
    if (done) begin
      status_r <= status_nxt;
      rec_r    <= rec_nxt;
      pos_r    <= pos_nxt;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = status_r;
  assign out_rsp.record_number = RECNUM_W'(rec_r);
  assign out_rsp.position      = POS_W'(pos_r);
  assign out_rsp.entry_count   = ENTCNT_W'(count_r);

  // The valid entries are strictly ascending, so a set less-than flag means
  // the cell below has one too, and at most one cell can match.
  `SKIT_ASSERT(a_lt_thermometer,
    (state_r == ST_WORK) |-> ((lt_vec & ~{lt_vec[TABLE_DEPTH-2:0], 1'b1}) == '0),
    "less-than flags are not a thermometer code")
  `SKIT_ASSERT(a_eq_unique,
    (state_r == ST_WORK) |-> $onehot0(eq_vec),
    "more than one cell matches the key")
  `SKIT_ASSERT(a_count_stable,
    !done |=> $stable(count_r) && $stable(nrec_r),
    "table state changed without a completed request")
  `SKIT_ASSERT(a_insert_advances,
    (done && upd && (op == CELL_INS)) |=>
      (nrec_r == $past(nrec_r) + NREC_W'(1)) && (count_r == $past(count_r) + CNT_W'(1)),
    "successful insert did not advance the counters")
  `SKIT_ASSERT_ALWAYS(a_count_bound,
    !rst_n || (count_r <= CNT_W'(TABLE_DEPTH)),
    "entry count exceeds table depth")

endmodule

`default_nettype wire

### sv/skit_cell.sv
// ----------------------------------------------------------------------------
// Sorted key index table - cell
// Holds one entry, compares it with the request key and shifts with its
// neighbors on insert and delete.
// ----------------------------------------------------------------------------
`default_nettype none

module skit_cell import skit_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      entry_valid,
  input  logic      prev_lt,
  input  entry_t    prev_entry,
  input  entry_t    next_entry,
  output entry_t    entry,
  output logic      lt,
  output logic      eq
);

  entry_t entry_r, entry_nxt;
  logic   lt_r, eq_r;

  // Cells below the slot keep their entry; the rest move one place.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.upd && !lt_r) begin
      case (ctl.op)
        CELL_INS: entry_nxt = prev_lt ? ctl.new_entry : prev_entry;
        CELL_DEL: entry_nxt = next_entry;
        default:  entry_nxt = entry_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.cmp) begin
      lt_r <= entry_valid && (entry_r.key < ctl.cmp_key);
      eq_r <= entry_valid && (entry_r.key == ctl.cmp_key);
    end
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

`default_nettype wire

### sv/skit_resolve.sv
// ----------------------------------------------------------------------------
// Sorted key index table - flag resolver
// Turns the chain's less-than and equal flags into slot, hit and the record
// number of the matching cell.
// ----------------------------------------------------------------------------
`default_nettype none

module skit_resolve import skit_pkg::*; (
  input  logic [TABLE_DEPTH-1:0] lt_vec,
  input  logic [TABLE_DEPTH-1:0] eq_vec,
  input  entry_t                 entries [TABLE_DEPTH],
  output resolve_t               res
);

  // The less-than flags form a thermometer; the slot is where it ends.
  always_comb begin
    logic [CNT_W-1:0]       slot_acc;
    logic [RECORD_BITS-1:0] rec_acc;
    logic [TABLE_DEPTH-1:0] below_vec;
    slot_acc  = '0;
    rec_acc   = '0;
    below_vec = {lt_vec[TABLE_DEPTH-2:0], 1'b1};
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (below_vec[i] && !lt_vec[i]) begin
        slot_acc = slot_acc | CNT_W'(i);
      end
      if (eq_vec[i]) begin
        rec_acc = rec_acc | entries[i].rec;
      end
    end
    res.slot    = lt_vec[TABLE_DEPTH-1] ? CNT_W'(TABLE_DEPTH) : slot_acc;
    res.hit     = |eq_vec;
    res.hit_rec = rec_acc;
  end

endmodule

`default_nettype wire
